### hw/rtl/saat_pkg.sv
// ----------------------------------------------------------------------------
// saat_pkg: shared types and constants for the stylus tilt converter
// fixed-point formats, cordic arctangent table and division reciprocals
// ----------------------------------------------------------------------------
package saat_pkg;

	// datapath word for q30 angles and vector components
	localparam int W = 34;
	typedef logic signed [W-1:0] word_t;

	// q30 angle constants
	localparam longint unsigned PI_Q30       = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
	localparam longint unsigned INV_GAIN_Q30 = 64'd652032875;

	// hundredths of a degree to q16 radians: divisor is 18000 * 2^14
	localparam longint unsigned DEG_DIV      = 64'd18000 * 64'd16384;
	localparam longint unsigned PI_INT       = PI_Q30 / DEG_DIV;
	localparam longint unsigned PI_REM       = PI_Q30 - PI_INT * DEG_DIV;
	localparam longint unsigned DEG_RND      = 64'd18000 * 64'd8192;

	// reciprocals, floor form, corrected by one compare afterwards
	localparam int              RECIP_A_SHIFT = 44;
	localparam longint unsigned RECIP_18000   = (64'd1 << RECIP_A_SHIFT) / 64'd18000;
	localparam int              RECIP_D_SHIFT = 48;
	localparam longint unsigned RECIP_DEG     = (64'd18000 << RECIP_D_SHIFT) / PI_Q30;

	localparam int TILT_LIMIT = 9000;
	localparam int TABLE_LEN  = 24;

	// arctangent of 2^-i in q30
	function automatic word_t atan_entry(input logic [4:0] i);
		word_t v;
		case (i)
			5'd0:    v = word_t'(64'd843314857);
			5'd1:    v = word_t'(64'd497837829);
			5'd2:    v = word_t'(64'd263043837);
			5'd3:    v = word_t'(64'd133525159);
			5'd4:    v = word_t'(64'd67021687);
			5'd5:    v = word_t'(64'd33543516);
			5'd6:    v = word_t'(64'd16775851);
			5'd7:    v = word_t'(64'd8388437);
			5'd8:    v = word_t'(64'd4194283);
			5'd9:    v = word_t'(64'd2097149);
			5'd10:   v = word_t'(64'd1048576);
			5'd11:   v = word_t'(64'd524288);
			5'd12:   v = word_t'(64'd262144);
			5'd13:   v = word_t'(64'd131072);
			5'd14:   v = word_t'(64'd65536);
			5'd15:   v = word_t'(64'd32768);
			5'd16:   v = word_t'(64'd16384);
			5'd17:   v = word_t'(64'd8192);
			5'd18:   v = word_t'(64'd4096);
			5'd19:   v = word_t'(64'd2048);
			5'd20:   v = word_t'(64'd1024);
			5'd21:   v = word_t'(64'd512);
			5'd22:   v = word_t'(64'd256);
			5'd23:   v = word_t'(64'd128);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/stylus_altitude_azimuth_to_tilt.sv
// ----------------------------------------------------------------------------
// stylus_altitude_azimuth_to_tilt: stylus altitude/azimuth to x/y tilt
// fully pipelined cordic sin/cos, products and vectoring atan2
// ----------------------------------------------------------------------------
// Takes one transfer per cycle unless the output stalls and returns one
// result transfer per input, in order. Five stages turn degrees into q30
// radians, one folds the angle, CORDIC_STEPS (at most 24) rotation stages
// give sin and cos, two form the unit vector, one pre-rotates, as many
// vectoring stages give atan2 and five stages turn radians into tilt. The
// whole pipeline holds while a result waits at the output; a stall drops and
// repeats nothing. Tilts are in hundredths of a degree, clamped to +-9000.
module stylus_altitude_azimuth_to_tilt #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// altitude [13:0], azimuth [29:14], zero [31:30]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tilt_horizontal [14:0], tilt_vertical [29:15], zero [31:30]
	output logic [31:0] m_tdata
);

	localparam int N = (CORDIC_STEPS > saat_pkg::TABLE_LEN) ? saat_pkg::TABLE_LEN
		: CORDIC_STEPS;
	localparam int L = 2 * N + 14;
	localparam int W = saat_pkg::W;

	localparam saat_pkg::word_t PI_W   = saat_pkg::word_t'(saat_pkg::PI_Q30);
	localparam saat_pkg::word_t HALF_W = saat_pkg::word_t'(saat_pkg::HALF_PI_Q30);
	localparam saat_pkg::word_t GAIN_W = saat_pkg::word_t'(saat_pkg::INV_GAIN_Q30);

	logic         en;
	logic [L-1:0] vld_q;

	// whole pipeline advances unless the output holds an untaken result
	assign en       = !vld_q[L-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[L-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	// stage 1: range handling, lane 0 altitude, lane 1 azimuth
	logic [13:0] alt_raw;
	logic [15:0] azm_raw, azm_a;
	logic        azm_neg;
	logic [14:0] alt_mag, azm_mag;

	assign alt_raw = s_tdata[13:0];
	assign azm_raw = s_tdata[29:14];
	assign alt_mag = (alt_raw > 14'd9000) ? 15'd9000 : {1'b0, alt_raw};
	assign azm_a   = (azm_raw > 16'd36000) ? (azm_raw - 16'd36000) : azm_raw;
	assign azm_neg = azm_a > 16'd18000;
	assign azm_mag = azm_neg ? 15'(17'd36000 - {1'b0, azm_a}) : azm_a[14:0];

	logic [14:0] mag_s1 [2];
	logic        neg_s1 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1[0] <= alt_mag;
			neg_s1[0] <= 1'b0;
			mag_s1[1] <= azm_mag;
			neg_s1[1] <= azm_neg;
		end
	end

	// stages 2 to 5: q16 = round(mag * pi / 18000 * 2^16) via reciprocal
	logic [27:0] m_s2 [2], m_s3 [2], m_s4 [2];
	logic [17:0] base_s2 [2], base_s3 [2], base_s4 [2];
	logic        neg_s2 [2], neg_s3 [2], neg_s4 [2];
	logic [13:0] est_s3 [2], est_s4 [2];
	logic [27:0] e18_s4 [2];
	saat_pkg::word_t th_s5 [2];

	always_ff @(posedge clk) begin
		logic [47:0] p2;
		logic [57:0] p3;
		logic [27:0] r5;
		logic [17:0] q5;
		saat_pkg::word_t tp;
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				p2 = 48'(mag_s1[l]) * 48'(saat_pkg::PI_REM) + 48'(saat_pkg::DEG_RND);
				m_s2[l]    <= p2[41:14];
				base_s2[l] <= 18'(mag_s1[l]) * 18'(saat_pkg::PI_INT);
				neg_s2[l]  <= neg_s1[l];

				p3 = 58'(m_s2[l]) * 58'(saat_pkg::RECIP_18000);
				est_s3[l]  <= p3[57:saat_pkg::RECIP_A_SHIFT];
				m_s3[l]    <= m_s2[l];
				base_s3[l] <= base_s2[l];
				neg_s3[l]  <= neg_s2[l];

				e18_s4[l]  <= 28'(est_s3[l]) * 28'd18000;
				est_s4[l]  <= est_s3[l];
				m_s4[l]    <= m_s3[l];
				base_s4[l] <= base_s3[l];
				neg_s4[l]  <= neg_s3[l];

				r5 = m_s4[l] - e18_s4[l];
				q5 = base_s4[l] + 18'(est_s4[l]) + 18'(r5 >= 28'd18000);
				tp = saat_pkg::word_t'({q5, 14'b0});
				th_s5[l] <= neg_s4[l] ? -tp : tp;
			end
		end
	end

	// stage 6 and rotation stages: sin/cos cordic per lane
	saat_pkg::word_t rot_x_s [0:N][2];
	saat_pkg::word_t rot_y_s [0:N][2];
	saat_pkg::word_t rot_z_s [0:N][2];
	logic            rot_n_s [0:N][2];

	// fold angles beyond a quarter turn by pi
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				rot_x_s[0][l] <= GAIN_W;
				rot_y_s[0][l] <= '0;
				if (th_s5[l] > HALF_W) begin
					rot_z_s[0][l] <= th_s5[l] - PI_W;
					rot_n_s[0][l] <= 1'b1;
				end else if (th_s5[l] < -HALF_W) begin
					rot_z_s[0][l] <= th_s5[l] + PI_W;
					rot_n_s[0][l] <= 1'b1;
				end else begin
					rot_z_s[0][l] <= th_s5[l];
					rot_n_s[0][l] <= 1'b0;
				end
			end
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_rot
		localparam saat_pkg::word_t ANG = saat_pkg::atan_entry(5'(i - 1));
		// one rotation iteration
		always_ff @(posedge clk) begin
			saat_pkg::word_t dx, dy;
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					dx = rot_y_s[i-1][l] >>> (i - 1);
					dy = rot_x_s[i-1][l] >>> (i - 1);
					if (!rot_z_s[i-1][l][W-1]) begin
						rot_x_s[i][l] <= rot_x_s[i-1][l] - dx;
						rot_y_s[i][l] <= rot_y_s[i-1][l] + dy;
						rot_z_s[i][l] <= rot_z_s[i-1][l] - ANG;
					end else begin
						rot_x_s[i][l] <= rot_x_s[i-1][l] + dx;
						rot_y_s[i][l] <= rot_y_s[i-1][l] - dy;
						rot_z_s[i][l] <= rot_z_s[i-1][l] + ANG;
					end
					rot_n_s[i][l] <= rot_n_s[i-1][l];
				end
			end
		end
	end

	// restore sign of folded angles, then form the unit vector
	saat_pkg::word_t cos_p1 [2], sin_p1 [2];
	saat_pkg::word_t vx_p2, vy_p2, vz_p2;

	always_ff @(posedge clk) begin
		logic signed [63:0] px, py;
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				cos_p1[l] <= rot_n_s[N][l] ? -rot_x_s[N][l] : rot_x_s[N][l];
				sin_p1[l] <= rot_n_s[N][l] ? -rot_y_s[N][l] : rot_y_s[N][l];
			end
			px = 64'(signed'(cos_p1[1][31:0])) * 64'(signed'(sin_p1[0][31:0]));
			py = 64'(signed'(sin_p1[1][31:0])) * 64'(signed'(sin_p1[0][31:0]));
			vx_p2 <= saat_pkg::word_t'(px >>> 30);
			vy_p2 <= saat_pkg::word_t'(py >>> 30);
			vz_p2 <= cos_p1[0][W-1] ? '0 : cos_p1[0];
		end
	end

	// vectoring cordic: lane 0 atan2(z, x), lane 1 atan2(z, y)
	saat_pkg::word_t vec_x_s [0:N][2];
	saat_pkg::word_t vec_y_s [0:N][2];
	saat_pkg::word_t vec_a_s [0:N][2];
	logic            vec_0_s [0:N][2];

	// pre-rotate by a quarter turn when x is negative
	always_ff @(posedge clk) begin
		saat_pkg::word_t xa, ya;
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				xa = (l == 0) ? vx_p2 : vy_p2;
				ya = vz_p2;
				vec_0_s[0][l] <= (xa == '0) && (ya == '0);
				if (xa[W-1]) begin
					if (!ya[W-1]) begin
						vec_x_s[0][l] <= ya;
						vec_y_s[0][l] <= -xa;
						vec_a_s[0][l] <= HALF_W;
					end else begin
						vec_x_s[0][l] <= -ya;
						vec_y_s[0][l] <= xa;
						vec_a_s[0][l] <= -HALF_W;
					end
				end else begin
					vec_x_s[0][l] <= xa;
					vec_y_s[0][l] <= ya;
					vec_a_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_vec
		localparam saat_pkg::word_t ANG = saat_pkg::atan_entry(5'(i - 1));
		// one vectoring iteration
		always_ff @(posedge clk) begin
			saat_pkg::word_t dx, dy;
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					dx = vec_y_s[i-1][l] >>> (i - 1);
					dy = vec_x_s[i-1][l] >>> (i - 1);
					if (!vec_y_s[i-1][l][W-1] && (vec_y_s[i-1][l] != '0)) begin
						vec_x_s[i][l] <= vec_x_s[i-1][l] + dx;
						vec_y_s[i][l] <= vec_y_s[i-1][l] - dy;
						vec_a_s[i][l] <= vec_a_s[i-1][l] + ANG;
					end else begin
						vec_x_s[i][l] <= vec_x_s[i-1][l] - dx;
						vec_y_s[i][l] <= vec_y_s[i-1][l] + dy;
						vec_a_s[i][l] <= vec_a_s[i-1][l] - ANG;
					end
					vec_0_s[i][l] <= vec_0_s[i-1][l];
				end
			end
		end
	end

	// radians to hundredths of a degree, truncated, then tilt and clamp
	logic [31:0]        mag_d1 [2];
	logic               neg_d1 [2], neg_d2 [2], neg_d3 [2];
	logic [14:0]        est_d2 [2], est_d3 [2];
	logic [47:0]        m18_d2 [2], m18_d3 [2], ep_d3 [2];
	logic signed [16:0] hs_d4 [2];
	logic [14:0]        tilt_d5 [2];

	always_ff @(posedge clk) begin
		saat_pkg::word_t r, ra;
		logic [63:0]        pd;
		logic [47:0]        rem;
		logic [15:0]        h;
		logic signed [16:0] t;
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				r  = vec_0_s[N][l] ? '0 : vec_a_s[N][l];
				ra = r[W-1] ? -r : r;
				mag_d1[l] <= ra[31:0];
				neg_d1[l] <= r[W-1];

				pd = 64'(mag_d1[l]) * 64'(saat_pkg::RECIP_DEG);
				est_d2[l] <= pd[62:saat_pkg::RECIP_D_SHIFT];
				m18_d2[l] <= 48'(mag_d1[l]) * 48'd18000;
				neg_d2[l] <= neg_d1[l];

				ep_d3[l]  <= 48'(est_d2[l]) * 48'(saat_pkg::PI_Q30);
				est_d3[l] <= est_d2[l];
				m18_d3[l] <= m18_d2[l];
				neg_d3[l] <= neg_d2[l];

				rem = m18_d3[l] - ep_d3[l];
				h   = 16'(est_d3[l]) + 16'(rem >= 48'(saat_pkg::PI_Q30));
				hs_d4[l] <= neg_d3[l] ? -signed'({1'b0, h}) : signed'({1'b0, h});

				if (l == 0) begin
					t = 17'(saat_pkg::TILT_LIMIT) - hs_d4[l];
				end else begin
					t = hs_d4[l] - 17'(saat_pkg::TILT_LIMIT);
				end
				if (t > 17'sd9000) begin
					tilt_d5[l] <= 15'd9000;
				end else if (t < -17'sd9000) begin
					tilt_d5[l] <= 15'(-17'sd9000);
				end else begin
					tilt_d5[l] <= t[14:0];
				end
			end
		end
	end

	assign m_tdata = {2'b00, tilt_d5[1], tilt_d5[0]};

endmodule

### tb/tb_stylus_altitude_azimuth_to_tilt.sv
// ----------------------------------------------------------------------------
// tb_stylus_altitude_azimuth_to_tilt: testbench for the stylus tilt converter
// drives altitude/azimuth transfers, predicts both tilts in fixed point and
// compares every result transfer in order, under several idle and stall phases
// ----------------------------------------------------------------------------
module tb_stylus_altitude_azimuth_to_tilt;

	localparam int STEPS     = 16;
	localparam int LATENCY   = 2 * STEPS + 14;
	localparam int TABLE_N   = 24;
	localparam longint PI_Q  = 64'sd3373259426;
	localparam longint HPI_Q = 64'sd1686629713;
	localparam longint GAIN  = 64'sd652032875;
	localparam int LIMIT     = 9000;

	typedef struct packed {
		logic signed [14:0] vert;
		logic signed [14:0] horz;
	} tilt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// altitude [13:0], azimuth [29:14], zero [31:30]
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// tilt_horizontal [14:0], tilt_vertical [29:15], zero [31:30]
	logic [31:0] m_tdata;

	tilt_t tilt_queue[$];
	int    mismatches;
	int    send_idle_pct;
	int    recv_stall_pct;

	longint atan_lut[TABLE_N] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	stylus_altitude_azimuth_to_tilt #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// run limit
	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	// hundredths of a degree to q30 radians through q16 rounding
	function automatic longint deg_to_rad(input int d);
		longint unsigned m;
		longint unsigned q;
		m = (d < 0) ? -d : d;
		q = (m * 64'd3373259426 + 64'd18000 * 64'd8192) / (64'd18000 * 64'd16384);
		return (d < 0) ? -longint'(q << 14) : longint'(q << 14);
	endfunction

	task automatic rotate_sincos(input longint th, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN;
		y = 0;
		flip = 0;
		if (th > HPI_Q) begin
			th -= PI_Q;
			flip = 1;
		end else if (th < -HPI_Q) begin
			th += PI_Q;
			flip = 1;
		end
		z = th;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_lut[i];
			end else begin
				x += dx; y -= dy; z += atan_lut[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint vector_angle(input longint xa, input longint ya);
		longint x, y, acc, t, dx, dy;
		x = xa;
		y = ya;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = HPI_Q;
			end else begin
				t = x; x = -y; y = t; acc = -HPI_Q;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; acc += atan_lut[i];
			end else begin
				x -= dx; y += dy; acc -= atan_lut[i];
			end
		end
		return acc;
	endfunction

	function automatic longint rad_to_deg(input longint r);
		longint unsigned m;
		longint q;
		m = (r < 0) ? -r : r;
		q = longint'(m * 64'd18000 / 64'd3373259426);
		return (r < 0) ? -q : q;
	endfunction

	function automatic logic [14:0] clamp_tilt(input longint v);
		if (v > LIMIT) v = LIMIT;
		if (v < -LIMIT) v = -LIMIT;
		return v[14:0];
	endfunction

	// expected tilts for one stylus report
	task automatic predict_tilt(input logic [13:0] alt_in, input logic [15:0] azm_in);
		int alt, azm;
		longint ca, sa, cz, sz, x, y, z;
		tilt_t t;
		alt = alt_in;
		azm = azm_in;
		if (alt > 9000) alt = 9000;
		if (azm > 36000) azm -= 36000;
		if (azm > 18000) azm -= 36000;
		rotate_sincos(deg_to_rad(alt), ca, sa);
		rotate_sincos(deg_to_rad(azm), cz, sz);
		x = (sa * cz) >>> 30;
		y = (sa * sz) >>> 30;
		z = (ca < 0) ? 0 : ca;
		t.horz = clamp_tilt(9000 - rad_to_deg(vector_angle(x, z)));
		t.vert = clamp_tilt(rad_to_deg(vector_angle(y, z)) - 9000);
		tilt_queue.push_back(t);
	endtask

	// send one report and wait for its transfer
	task automatic send_report(input logic [13:0] alt, input logic [15:0] azm);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, azm, alt};
		predict_tilt(alt, azm);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic end_burst;
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver stall and result check
	always @(posedge clk) begin
		tilt_t got, want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				got = m_tdata[29:0];
				if (tilt_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = tilt_queue.pop_front();
					if (got.horz !== want.horz || got.vert !== want.vert ||
						m_tdata[31:30] !== 2'b00) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp h=%0d v=%0d got h=%0d v=%0d",
								want.horz, want.vert, got.horz, got.vert);
					end
				end
			end
		end
	end

	task automatic test_directed;
		logic [13:0] alts[7] = '{0, 1, 4500, 8999, 9000, 9001, 14'h3FFF};
		logic [15:0] azms[11] = '{0, 1, 9000, 17999, 18000, 18001, 27000,
			35999, 36000, 36001, 16'hFFFF};
		for (int i = 0; i < 7; i++) send_report(alts[i], 16'd4500);
		for (int i = 0; i < 11; i++) send_report(14'd3000, azms[i]);
		send_report(14'h3FFF, 16'hFFFF);
		send_report(14'd9000, 16'd0);
		send_report(14'd9000, 16'd9000);
		end_burst();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_report(14'($urandom), 16'($urandom));
				1: send_report(14'($urandom_range(9000)),
					16'($urandom_range(36000) + 36000 * $urandom_range(1)));
				default: send_report(14'($urandom_range(9000)),
					16'($urandom_range(36000)));
			endcase
		end
		end_burst();
	endtask

	task automatic test_phase(input int idle, input int stall, input int n);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		test_random(n);
	endtask

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_phase(0, 0, 120);
		test_phase(74, 0, 110);
		test_phase(0, 74, 110);
		test_phase(10, 10, 110);
		recv_stall_pct = 0;
		while (tilt_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && tilt_queue.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/saat_pkg.sv
hw/rtl/stylus_altitude_azimuth_to_tilt.sv
tb/tb_stylus_altitude_azimuth_to_tilt.sv
